[rtl/hba_pkg.sv]
// shared constants, types and helper functions of the bitmap slot allocator
package hba_pkg;

  // pool geometry
  localparam int SLOTS      = 4096;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LEAF_BYTES = SLOTS / 8;
  localparam int L1_BYTES   = SLOTS / 64;
  localparam int GRP_BYTES  = SLOTS / 512;
  localparam int LEAF_AW    = SLOT_W - 3;
  localparam int L1_AW      = SLOT_W - 6;
  localparam int GRP_AW     = (GRP_BYTES > 1) ? $clog2(GRP_BYTES) : 1;

  // field widths
  localparam int SLOT_FW    = 12;
  localparam int COUNT_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int CMP_W      = (SLOT_W + 1 > COUNT_W) ? SLOT_W + 1 : COUNT_W;

  // slot count after reset
  localparam logic [COUNT_W-1:0] RESET_SLOT_COUNT = 13'd4096;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

  typedef logic [7:0] bmap_t;

  localparam bmap_t FULL_BYTE = 8'hff;

  // update of the top summary level
  typedef struct packed {
    logic              clr_all;
    logic              set_bit;
    logic              clr_bit;
    logic [GRP_AW-1:0] grp;
    logic [2:0]        pos;
  } grp_cmd_t;

  // lowest group byte with a free entry
  typedef struct packed {
    logic              found;
    logic [GRP_AW-1:0] grp;
    logic [2:0]        pos;
  } grp_find_t;

  // position of the lowest zero bit, 8 when the byte is full
  function automatic logic [3:0] lowest_zero(bmap_t b);
    logic [3:0] pos;
    pos = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) pos = 4'(i);
    end
    return pos;
  endfunction

endpackage

[rtl/hba_if.sv]
// request, response and configuration channels of the bitmap slot allocator

interface hba_req_if import hba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SLOT_FW-1:0] slot;
  modport source (output valid, kind, slot, input ready);
  modport sink (input valid, kind, slot, output ready);
endinterface

interface hba_rsp_if import hba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_FW-1:0]  granted_slot;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  free_count;
  modport source (output valid, granted_slot, status, free_count, input ready);
  modport sink (input valid, granted_slot, status, free_count, output ready);
endinterface

interface hba_cfg_if import hba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] slot_count;
  modport source (output valid, slot_count, input ready);
  modport sink (input valid, slot_count, output ready);
endinterface

[rtl/hierarchical_bitmap_slot_allocator_core.sv]
// allocate: states S_A_GRP, S_A_BYTE, S_A_LEAF, ending early when the summary shows a full pool
// free: states S_F_READ, S_F_CHECK, ending in S_F_READ when out of range; no new item until idle
// the sequencer reads one leaf ram and one level-1 ram, then writes back
// results wait in an output register; a new item is taken while one waits there
// reset and every slot_count write clear both rams, with no item taken
// reset is synchronous, active high
module hierarchical_bitmap_slot_allocator_core import hba_pkg::*; (
  input logic    clk,
  input logic    rst,
  hba_req_if.sink   req,
  hba_rsp_if.source rsp,
  hba_cfg_if.sink   cfg
);

  // sequencer states
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_A_GRP   = 3'd2;
  localparam logic [2:0] S_A_BYTE  = 3'd3;
  localparam logic [2:0] S_A_LEAF  = 3'd4;
  localparam logic [2:0] S_F_READ  = 3'd5;
  localparam logic [2:0] S_F_CHECK = 3'd6;

  function automatic logic [COUNT_W-1:0] sat_count(logic [COUNT_W-1:0] v);
    if (CMP_W'(v) > CMP_W'(SLOTS)) return COUNT_W'(SLOTS);
    return v;
  endfunction

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [LEAF_AW-1:0]  clr_addr;
  logic [COUNT_W-1:0]  active_cnt;
  logic [COUNT_W-1:0]  free_slots;
  logic [COUNT_W-1:0]  free_next;

  logic [SLOT_FW-1:0]  op_slot;
  logic [GRP_AW-1:0]   op_grp;
  logic [2:0]          op_b1;
  logic [L1_AW-1:0]    op_l1;
  logic [2:0]          op_b0;

  logic                out_valid;
  logic [SLOT_FW-1:0]  out_granted;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_free;

  logic                out_open;
  logic                commit;
  logic [STATUS_W-1:0] c_status;
  logic [SLOT_FW-1:0]  c_granted;

  logic                leaf_we, leaf_re;
  logic [LEAF_AW-1:0]  leaf_waddr, leaf_raddr;
  bmap_t               leaf_wdata, leaf_rdata;
  logic                l1_we, l1_re;
  logic [L1_AW-1:0]    l1_waddr, l1_raddr;
  bmap_t               l1_wdata, l1_rdata;

  grp_cmd_t            grp_cmd;
  grp_find_t           grp_find;

  logic [3:0]          lz_l1;
  logic [3:0]          lz_leaf;
  logic [L1_AW-1:0]    alloc_l1;
  logic [LEAF_AW-1:0]  alloc_lb;
  logic [SLOT_W-1:0]   alloc_idx;
  logic                alloc_ok;
  bmap_t               alloc_leaf;
  bmap_t               alloc_byte;
  logic [SLOT_W-1:0]   free_idx;
  logic [LEAF_AW-1:0]  free_lb;
  logic [L1_AW-1:0]    free_l1;
  logic                free_out;
  logic                free_used;

  // bitmap storage
  hba_ram #(.DEPTH(LEAF_BYTES), .WIDTH(8)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  hba_ram #(.DEPTH(L1_BYTES), .WIDTH(8)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  hba_group u_group (
    .clk  (clk),
    .rst  (rst),
    .cmd  (grp_cmd),
    .find (grp_find)
  );

  // handshake and output ports
  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = out_valid;
  assign rsp.granted_slot = out_granted;
  assign rsp.status       = out_status;
  assign rsp.free_count   = out_free;
  assign out_open         = !out_valid || rsp.ready;

  // allocate path decode
  assign lz_l1      = lowest_zero(l1_rdata);
  assign lz_leaf    = lowest_zero(leaf_rdata);
  assign alloc_l1   = L1_AW'({grp_find.grp, grp_find.pos});
  assign alloc_lb   = {op_l1, op_b0};
  assign alloc_idx  = {alloc_lb, lz_leaf[2:0]};
  assign alloc_ok   = !lz_leaf[3] && (CMP_W'(alloc_idx) < CMP_W'(active_cnt));
  assign alloc_leaf = leaf_rdata | (bmap_t'(1) << lz_leaf[2:0]);
  assign alloc_byte = l1_rdata | (bmap_t'(1) << op_b0);

  // free path decode
  assign free_idx  = SLOT_W'(op_slot);
  assign free_lb   = LEAF_AW'(free_idx >> 3);
  assign free_l1   = L1_AW'(free_idx >> 6);
  assign free_out  = CMP_W'(op_slot) >= CMP_W'(active_cnt);
  assign free_used = leaf_rdata[free_idx[2:0]];

  // sequencer next state, memory accesses and result
  always_comb begin
    state_next = state;
    free_next  = free_slots;
    commit     = 1'b0;
    c_status   = STAT_OK;
    c_granted  = '0;
    leaf_we    = 1'b0;
    leaf_waddr = clr_addr;
    leaf_wdata = '0;
    leaf_re    = 1'b0;
    leaf_raddr = free_lb;
    l1_we      = 1'b0;
    l1_waddr   = L1_AW'(clr_addr);
    l1_wdata   = '0;
    l1_re      = 1'b0;
    l1_raddr   = free_l1;
    grp_cmd    = '0;
    grp_cmd.clr_all = cfg.valid;
    unique case (state)
      S_CLEAR: begin
        leaf_we = 1'b1;
        l1_we   = 1'b1;
        if (clr_addr == LEAF_AW'(LEAF_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = (req.kind == KIND_ALLOC) ? S_A_GRP : S_F_READ;
      end
      S_A_GRP: begin
        if (free_slots == '0 || !grp_find.found) begin
          if (out_open) begin
            commit     = 1'b1;
            c_status   = STAT_FULL;
            state_next = S_IDLE;
          end
        end else begin
          l1_re      = 1'b1;
          l1_raddr   = alloc_l1;
          state_next = S_A_BYTE;
        end
      end
      S_A_BYTE: begin
        if (lz_l1[3]) begin
          if (out_open) begin
            commit     = 1'b1;
            c_status   = STAT_FULL;
            state_next = S_IDLE;
          end
        end else begin
          leaf_re    = 1'b1;
          leaf_raddr = {op_l1, lz_l1[2:0]};
          state_next = S_A_LEAF;
        end
      end
      S_A_LEAF: begin
        if (out_open) begin
          commit     = 1'b1;
          state_next = S_IDLE;
          if (alloc_ok) begin
            leaf_we    = 1'b1;
            leaf_waddr = alloc_lb;
            leaf_wdata = alloc_leaf;
            // propagate fullness upward
            if (alloc_leaf == FULL_BYTE) begin
              l1_we    = 1'b1;
              l1_waddr = op_l1;
              l1_wdata = alloc_byte;
              if (alloc_byte == FULL_BYTE) begin
                grp_cmd.set_bit = 1'b1;
                grp_cmd.grp     = op_grp;
                grp_cmd.pos     = op_b1;
              end
            end
            free_next = free_slots - COUNT_W'(1);
            c_granted = SLOT_FW'(alloc_idx);
          end else begin
            c_status = STAT_FULL;
          end
        end
      end
      S_F_READ: begin
        if (free_out) begin
          if (out_open) begin
            commit     = 1'b1;
            c_status   = STAT_RANGE;
            state_next = S_IDLE;
          end
        end else begin
          leaf_re    = 1'b1;
          l1_re      = 1'b1;
          state_next = S_F_CHECK;
        end
      end
      S_F_CHECK: begin
        if (out_open) begin
          commit     = 1'b1;
          state_next = S_IDLE;
          if (!free_used) begin
            c_status = STAT_NOT_USED;
          end else begin
            // clear the slot and every summary bit above it
            leaf_we         = 1'b1;
            leaf_waddr      = free_lb;
            leaf_wdata      = leaf_rdata & ~(bmap_t'(1) << free_idx[2:0]);
            l1_we           = 1'b1;
            l1_waddr        = free_l1;
            l1_wdata        = l1_rdata & ~(bmap_t'(1) << free_lb[2:0]);
            grp_cmd.clr_bit = 1'b1;
            grp_cmd.grp     = GRP_AW'(free_l1 >> 3);
            grp_cmd.pos     = free_l1[2:0];
            free_next       = free_slots + COUNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // control state, reinit on reset or slot_count write
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      active_cnt <= sat_count(RESET_SLOT_COUNT);
      free_slots <= sat_count(RESET_SLOT_COUNT);
    end else if (cfg.valid) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      active_cnt <= sat_count(cfg.slot_count);
      free_slots <= sat_count(cfg.slot_count);
    end else begin
      state      <= state_next;
      free_slots <= free_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + LEAF_AW'(1);
    end
  end

  // per-item operands
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) op_slot <= req.slot;
    if (state == S_A_GRP) begin
      op_grp <= grp_find.grp;
      op_b1  <= grp_find.pos;
      op_l1  <= alloc_l1;
    end
    if (state == S_A_BYTE) op_b0 <= lz_l1[2:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_granted <= c_granted;
      out_status  <= c_status;
      out_free    <= free_next;
    end
  end

endmodule

[rtl/hba_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
module hba_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and read port, read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/hba_group.sv]
// top summary level: one bit per full level-1 byte, with first-free search
module hba_group import hba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  grp_cmd_t  cmd,
  output grp_find_t find
);

  bmap_t      grp_bits [GRP_BYTES];
  logic [3:0] grp_lz   [GRP_BYTES];

  // clear on reset or reinit, otherwise set or clear one bit
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      for (int i = 0; i < GRP_BYTES; i++) grp_bits[i] <= '0;
    end else if (cmd.set_bit) begin
      grp_bits[cmd.grp][cmd.pos] <= 1'b1;
    end else if (cmd.clr_bit) begin
      grp_bits[cmd.grp][cmd.pos] <= 1'b0;
    end
  end

  // lowest zero of each group byte
  always_comb begin
    for (int i = 0; i < GRP_BYTES; i++) grp_lz[i] = lowest_zero(grp_bits[i]);
  end

  // lowest group byte that is not full
  always_comb begin
    find = '0;
    for (int i = GRP_BYTES - 1; i >= 0; i--) begin
      if (grp_bits[i] != FULL_BYTE) begin
        find.found = 1'b1;
        find.grp   = GRP_AW'(i);
        find.pos   = grp_lz[i][2:0];
      end
    end
  end

endmodule

[rtl/hba_checker.sv]
// port-level checker of the bitmap slot allocator and its bind
module hba_checker import hba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [SLOT_FW-1:0]  rsp_granted_slot,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [COUNT_W-1:0]  rsp_free_count,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  // one item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted in back-to-back cycles");

  // a failed request never grants a slot
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_OK |-> rsp_granted_slot == '0)
    else $error("nonzero granted slot on a failed request");

  // free count never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> CMP_W'(rsp_free_count) <= CMP_W'(SLOTS))
    else $error("free count above pool size");

  // reinit blocks requests while the bitmaps are cleared
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !req_ready)
    else $error("request taken during bitmap clear");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_slot)
      && $stable(rsp_status) && $stable(rsp_free_count))
    else $error("stalled result changed");

endmodule

bind hierarchical_bitmap_slot_allocator_core hba_checker u_hba_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_granted_slot (rsp.granted_slot),
  .rsp_status       (rsp.status),
  .rsp_free_count   (rsp.free_count),
  .cfg_valid        (cfg.valid),
  .cfg_ready        (cfg.ready)
);
